/* hdl/bht_pkg.sv */
package bht_pkg;

   localparam int Buckets = 8;
   localparam int Slots = 16;
   localparam int BktW = $clog2(Buckets) > 0 ? $clog2(Buckets) : 1;
   localparam int SlotW = $clog2(Slots) > 0 ? $clog2(Slots) : 1;
   localparam int FillW = $clog2(Slots + 1);
   localparam int TotW = $clog2(Buckets * Slots + 1);

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_LOOKUP = 2'd1;
   localparam logic [1:0] FUNC_REMOVE = 2'd2;

   localparam logic [2:0] ST_DONE = 3'd0;
   localparam logic [2:0] ST_FOUND = 3'd1;
   localparam logic [2:0] ST_MISSING = 3'd2;
   localparam logic [2:0] ST_BUCKET_FULL = 3'd3;
   localparam logic [2:0] ST_TABLE_FULL = 3'd4;
   localparam logic [2:0] ST_EMPTY = 3'd5;

   typedef struct packed {
      logic [1:0] func;
      logic [31:0] key;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] slot;
      logic [2:0] bucket;
      logic [7:0] total;
   } rsp_type;

   // Control that every cell of the chain sees in the same cycle.
   typedef struct packed {
      logic load;
      logic rotate;
      logic store;
      logic remove;
      logic [SlotW-1:0] rm_slot;
   } cell_ctl_type;

endpackage

/* hdl/bht_cell.sv */
// One slot of the working bucket. During a scan the chain rotates by one slot a
// cycle, so the key in cell zero walks through every slot of the bucket in turn.
module bht_cell (
   input  logic                     clock,
   input  bht_pkg::cell_ctl_type    ctl,
   input  logic [bht_pkg::SlotW-1:0] index,
   input  logic [31:0]              load_key,
   input  logic [31:0]              next_key,
   input  logic [31:0]              after_key,
   output logic [31:0]              key
);

   logic [31:0] key_ff;
   logic [31:0] key_in;

   // Load from memory, rotate toward cell zero, or close the gap of a removal.
   always_comb begin
      key_in = key_ff;
      if (ctl.load) begin
         key_in = load_key;
      end else if (ctl.rotate) begin
         key_in = next_key;
      end else if (ctl.remove && index >= ctl.rm_slot) begin
         key_in = after_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key = key_ff;

endmodule

/* hdl/bucketed_hash_table.sv */
// Hash table of fixed buckets keyed by key modulo the bucket count. Each start
// transfer takes one operation and yields exactly one result on the rsp_ ports,
// flagged by rsp_valid for one cycle; the receiver cannot stall it, so it must
// take it in that cycle. busy is high from the start transfer until the result
// cycle. An insert, an unused code, or a lookup or remove on an empty table goes
// through the bucket read, load, write and result states; a lookup or remove on
// a non-empty table adds a scan over all Slots slots that rotates the bucket
// through the chain of slot cells one slot a cycle.
module bucketed_hash_table (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  bht_pkg::req_type    req_data,
   output logic                rsp_valid,
   output bht_pkg::rsp_type    rsp_data
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_LOAD = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_WRITE = 3'd4;
   localparam logic [2:0] S_RESP = 3'd5;

   localparam int Slots = bht_pkg::Slots;
   localparam int SlotW = bht_pkg::SlotW;
   localparam int FillW = bht_pkg::FillW;
   localparam int TotW = bht_pkg::TotW;
   localparam int BktW = bht_pkg::BktW;

   logic [2:0] state_ff, state_in;
   bht_pkg::req_type req_ff, req_in;
   logic [FillW-1:0] fill_ff [bht_pkg::Buckets];
   logic [TotW-1:0] total_ff, total_in;
   logic [FillW-1:0] cnt_ff, cnt_in;
   logic hit_ff, hit_in;
   logic [SlotW-1:0] pos_ff, pos_in;
   logic [2:0] status_ff, status_in;
   logic [SlotW-1:0] rslot_ff, rslot_in;
   logic fill_we;
   logic [FillW-1:0] fill_wdata;

   // Bucket memory: one row of Slots keys per bucket.
   logic [Slots*32-1:0] mem [bht_pkg::Buckets];
   logic [Slots*32-1:0] rd_row_ff;
   logic [Slots*32-1:0] wr_row;
   logic mem_we;

   logic [BktW-1:0] bkt;
   logic [FillW-1:0] fill;
   bht_pkg::cell_ctl_type ctl;
   logic [31:0] cell_key [Slots];
   logic ins_put;

   assign bkt = BktW'(req_ff.key % bht_pkg::Buckets);
   assign fill = fill_ff[bkt];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[bkt] <= wr_row;
      end
      rd_row_ff <= mem[bkt];
   end

   // The insert writes its key into the row the cells hold.
   assign ins_put = state_ff == S_WRITE && req_ff.func == bht_pkg::FUNC_INSERT
                    && status_ff == bht_pkg::ST_DONE;

   // Chain of slot cells.
   for (genvar i = 0; i < Slots; i++) begin : g_cell
      bht_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .index     (SlotW'(i)),
         .load_key  (rd_row_ff[i*32 +: 32]),
         .next_key  (cell_key[(i + 1) % Slots]),
         .after_key (cell_key[(i + 1) % Slots]),
         .key       (cell_key[i])
      );
      assign wr_row[i*32 +: 32] = (ins_put && rslot_ff == SlotW'(i)) ? req_ff.key
                                                                    : cell_key[i];
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      total_in = total_ff;
      cnt_in = cnt_ff;
      hit_in = hit_ff;
      pos_in = pos_ff;
      status_in = status_ff;
      rslot_in = rslot_ff;
      fill_we = 1'b0;
      fill_wdata = fill;
      mem_we = 1'b0;
      ctl = '0;
      ctl.rm_slot = pos_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_LOAD;
            cnt_in = '0;
            hit_in = 1'b0;
            pos_in = '0;
            rslot_in = '0;
            status_in = bht_pkg::ST_DONE;
            unique case (req_ff.func)
               bht_pkg::FUNC_INSERT: begin
                  if (32'(total_ff) >= bht_pkg::Buckets * Slots) begin
                     status_in = bht_pkg::ST_TABLE_FULL;
                  end else if (32'(fill) >= Slots) begin
                     status_in = bht_pkg::ST_BUCKET_FULL;
                  end else begin
                     rslot_in = SlotW'(fill);
                  end
               end
               bht_pkg::FUNC_LOOKUP, bht_pkg::FUNC_REMOVE: begin
                  if (total_ff == '0) begin
                     status_in = bht_pkg::ST_EMPTY;
                  end
               end
               default: begin
               end
            endcase
         end
         S_LOAD: begin
            ctl.load = 1'b1;
            if ((req_ff.func == bht_pkg::FUNC_LOOKUP || req_ff.func == bht_pkg::FUNC_REMOVE)
                && status_ff == bht_pkg::ST_DONE) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_SCAN: begin
            // Compare the key in cell zero, then rotate.
            ctl.rotate = 1'b1;
            if (!hit_ff && cnt_ff < fill && cell_key[0] == req_ff.key) begin
               hit_in = 1'b1;
               pos_in = SlotW'(cnt_ff);
            end
            cnt_in = cnt_ff + 1'b1;
            if (32'(cnt_ff) == Slots - 1) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            state_in = S_RESP;
            if (req_ff.func == bht_pkg::FUNC_INSERT) begin
               if (status_ff == bht_pkg::ST_DONE) begin
                  mem_we = 1'b1;
                  fill_we = 1'b1;
                  fill_wdata = fill + 1'b1;
                  total_in = total_ff + 1'b1;
               end
            end else if ((req_ff.func == bht_pkg::FUNC_LOOKUP
                          || req_ff.func == bht_pkg::FUNC_REMOVE)
                         && status_ff == bht_pkg::ST_DONE) begin
               if (!hit_ff) begin
                  status_in = bht_pkg::ST_MISSING;
               end else begin
                  rslot_in = pos_ff;
                  if (req_ff.func == bht_pkg::FUNC_LOOKUP) begin
                     status_in = bht_pkg::ST_FOUND;
                  end else begin
                     ctl.remove = 1'b1;
                     fill_we = 1'b1;
                     fill_wdata = fill - 1'b1;
                     total_in = total_ff - 1'b1;
                  end
               end
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
            if (req_ff.func == bht_pkg::FUNC_REMOVE && status_ff == bht_pkg::ST_DONE) begin
               mem_we = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         total_ff <= '0;
         for (int b = 0; b < bht_pkg::Buckets; b++) begin
            fill_ff[b] <= '0;
         end
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         if (fill_we) begin
            fill_ff[bkt] <= fill_wdata;
         end
      end
      req_ff <= req_in;
      cnt_ff <= cnt_in;
      hit_ff <= hit_in;
      pos_ff <= pos_in;
      status_ff <= status_in;
      rslot_ff <= rslot_in;
   end

   assign busy = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_RESP;
   assign rsp_data.status = status_ff;
   assign rsp_data.slot = 4'(rslot_ff);
   assign rsp_data.bucket = 3'(bkt);
   assign rsp_data.total = 8'(total_ff);

`ifndef SYNTH
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      32'(total_ff) <= bht_pkg::Buckets * Slots)
      else $error("total exceeds capacity");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back to back results");
   a_start_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("start not taken");
   a_total_step: assert property (@(posedge clock) disable iff (reset)
      !fill_we |=> $stable(total_ff))
      else $error("total changed without fill update");
`endif

endmodule

/* test/tb_bucketed_hash_table.sv */
module tb_bucketed_hash_table;

   localparam int Buckets = bht_pkg::Buckets;
   localparam int Slots = bht_pkg::Slots;
   localparam int Capacity = Buckets * Slots;
   localparam int CycleLimit = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   bht_pkg::req_type req_data = '0;
   logic rsp_valid;
   bht_pkg::rsp_type rsp_data;

   bucketed_hash_table uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow copy of the table contents and the fill counts.
   logic [31:0] shadow_keys [Buckets][Slots];
   int shadow_fill [Buckets];
   int shadow_total;

   bht_pkg::req_type pending_ops[$];
   bht_pkg::rsp_type expected_rsps[$];
   int errors = 0;
   int cycles = 0;
   int checked = 0;
   int op_hist [4];

   // Computes the result of one operation and updates the shadow table.
   function automatic bht_pkg::rsp_type apply_op(bht_pkg::req_type op);
      bht_pkg::rsp_type r;
      int b;
      int pos;
      r = '0;
      b = op.key % Buckets;
      pos = -1;
      r.status = bht_pkg::ST_DONE;
      if (op.func == bht_pkg::FUNC_INSERT) begin
         if (shadow_total >= Capacity) begin
            r.status = bht_pkg::ST_TABLE_FULL;
         end else if (shadow_fill[b] >= Slots) begin
            r.status = bht_pkg::ST_BUCKET_FULL;
         end else begin
            r.slot = 4'(shadow_fill[b]);
            shadow_keys[b][shadow_fill[b]] = op.key;
            shadow_fill[b]++;
            shadow_total++;
         end
      end else if (op.func == bht_pkg::FUNC_LOOKUP || op.func == bht_pkg::FUNC_REMOVE) begin
         if (shadow_total == 0) begin
            r.status = bht_pkg::ST_EMPTY;
         end else begin
            for (int i = 0; i < shadow_fill[b]; i++) begin
               if (pos < 0 && shadow_keys[b][i] == op.key) pos = i;
            end
            if (pos < 0) begin
               r.status = bht_pkg::ST_MISSING;
            end else begin
               r.slot = 4'(pos);
               if (op.func == bht_pkg::FUNC_LOOKUP) begin
                  r.status = bht_pkg::ST_FOUND;
               end else begin
                  for (int i = pos; i + 1 < shadow_fill[b]; i++)
                     shadow_keys[b][i] = shadow_keys[b][i + 1];
                  shadow_fill[b]--;
                  shadow_total--;
               end
            end
         end
      end
      r.bucket = 3'(b);
      r.total = 8'(shadow_total);
      return r;
   endfunction

   function automatic bht_pkg::req_type make_op(logic [1:0] f, logic [31:0] k);
      bht_pkg::req_type op;
      op.func = f;
      op.key = k;
      return op;
   endfunction

   // Keys drawn mostly from a small pool so that lookups and removes hit.
   function automatic logic [31:0] pick_key();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 7) return $urandom_range(0, 47);
      else if (sel < 8) return 32'hFFFF_FFF0 + $urandom_range(0, 15);
      else return $urandom;
   endfunction

   // Driver: bursts of transfers separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (start && !busy) begin
            void'(pending_ops.pop_front());
         end
         if (start && !busy || !start) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               start <= 1'b0;
            end else if (pending_ops.size() > 0) begin
               start <= 1'b1;
               req_data <= pending_ops[0];
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 30);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Prediction happens at the accepting edge, in transfer order.
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         expected_rsps.push_back(apply_op(req_data));
         op_hist[req_data.func]++;
      end
   end

   // Monitor: each result lasts one cycle and is compared with the oldest expectation.
   always @(posedge clock) begin
      bht_pkg::rsp_type exp_rsp;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t unexpected result %p", $time, rsp_data);
            errors++;
         end else begin
            exp_rsp = expected_rsps.pop_front();
            checked++;
            if (rsp_data.status !== exp_rsp.status || rsp_data.slot !== exp_rsp.slot ||
                rsp_data.bucket !== exp_rsp.bucket || rsp_data.total !== exp_rsp.total) begin
               $display("%0t mismatch: expected %p actual %p", $time, exp_rsp, rsp_data);
               errors++;
            end
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      if (cycles > CycleLimit) begin
         $display("[bucketed_hash_table] ERROR");
         $finish;
      end
   end

   initial begin
      logic [1:0] f;
      for (int b = 0; b < Buckets; b++) shadow_fill[b] = 0;
      shadow_total = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, extreme keys, unused code, bucket and table full.
      pending_ops.push_back(make_op(bht_pkg::FUNC_LOOKUP, 32'd5));
      pending_ops.push_back(make_op(bht_pkg::FUNC_REMOVE, 32'hFFFF_FFFF));
      pending_ops.push_back(make_op(2'd3, 32'hFFFF_FFFF));
      pending_ops.push_back(make_op(bht_pkg::FUNC_INSERT, 32'h0));
      pending_ops.push_back(make_op(bht_pkg::FUNC_INSERT, 32'hFFFF_FFFF));
      pending_ops.push_back(make_op(bht_pkg::FUNC_INSERT, 32'h0));
      pending_ops.push_back(make_op(bht_pkg::FUNC_LOOKUP, 32'h0));
      pending_ops.push_back(make_op(bht_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF));
      pending_ops.push_back(make_op(bht_pkg::FUNC_LOOKUP, 32'h8));
      pending_ops.push_back(make_op(bht_pkg::FUNC_REMOVE, 32'h0));
      pending_ops.push_back(make_op(bht_pkg::FUNC_REMOVE, 32'hAAAA_AAAA));
      pending_ops.push_back(make_op(2'd3, 32'h5555_5555));
      for (int i = 0; i < Slots + 1; i++)
         pending_ops.push_back(make_op(bht_pkg::FUNC_INSERT, 32'h100 + 8 * i));
      // Fill the whole table by walking the buckets in turn, then push past full.
      for (int i = 0; i < Capacity + 4; i++)
         pending_ops.push_back(make_op(bht_pkg::FUNC_INSERT,
                                       ($urandom & 32'hFFFF_FFF8) | 32'(i % Buckets)));
      for (int i = 0; i < 40; i++)
         pending_ops.push_back(make_op($urandom_range(0, 1) ? bht_pkg::FUNC_LOOKUP
                                                            : bht_pkg::FUNC_REMOVE,
                                       $urandom_range(0, 1) ? 32'h100 : $urandom));
      // Drain the table with removes of stored keys and random ones.
      for (int i = 0; i < 200; i++)
         pending_ops.push_back(make_op(bht_pkg::FUNC_REMOVE, $urandom_range(0, 1) ?
                                       32'h100 + 8 * $urandom_range(0, 16) : $urandom));

      // Random phases that swing between filling and draining.
      for (int ph = 0; ph < 8; ph++) begin
         for (int i = 0; i < 110; i++) begin
            int r;
            r = $urandom_range(0, 99);
            if (ph % 2 == 0) f = (r < 60) ? bht_pkg::FUNC_INSERT :
                                 (r < 80) ? bht_pkg::FUNC_LOOKUP :
                                 (r < 97) ? bht_pkg::FUNC_REMOVE : 2'd3;
            else f = (r < 20) ? bht_pkg::FUNC_INSERT : (r < 50) ? bht_pkg::FUNC_LOOKUP :
                     (r < 97) ? bht_pkg::FUNC_REMOVE : 2'd3;
            pending_ops.push_back(make_op(f, pick_key()));
         end
      end

      wait (pending_ops.size() == 0 && expected_rsps.size() == 0);
      repeat (40) @(posedge clock);
      $display("Checked %0d results: %0d inserts, %0d lookups, %0d removes, %0d unused.",
               checked, op_hist[0], op_hist[1], op_hist[2], op_hist[3]);
      $display("Covered empty, missing, bucket full and table full cases.");
      if (errors == 0) begin
         $display("[bucketed_hash_table] OK");
      end else begin
         $display("[bucketed_hash_table] ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/bht_pkg.sv
hdl/bht_cell.sv
hdl/bucketed_hash_table.sv
test/tb_bucketed_hash_table.sv
